// File: hw/rtl/euler_normal_flux_2d_macros.svh
// assertion macros for the euler normal flux block
// no dependencies; included by the top level only
`ifndef EULER_NORMAL_FLUX_2D_MACROS_SVH
`define EULER_NORMAL_FLUX_2D_MACROS_SVH
`ifndef SYNTHESIS
`define EFN_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`define EFN_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define EFN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define EFN_ASSERT_NEVER(label, clk, rst, cond, msg)
`define EFN_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define EFN_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: hw/rtl/efn_pkg.sv
// shared types, constants and saturate/round helpers for the euler flux block
// no dependencies
package efn_pkg;

  typedef logic signed [31:0] word_t;

  localparam int SAT_W = 72;
  localparam logic [18:0] GAMMA_RESET = 19'd91750;

  localparam logic signed [SAT_W-1:0] WORD_MAX = SAT_W'(64'sd2147483647);
  localparam logic signed [SAT_W-1:0] WORD_MIN = -SAT_W'(64'sd2147483648);

  // cell item as captured at the input
  typedef struct packed {
    word_t nx;
    word_t ny;
    word_t rho;
    word_t m1;
    word_t m2;
    word_t m3;
    word_t e;
    logic  bad;
  } item_t;

  // values carried down the arithmetic pipe
  typedef struct packed {
    word_t nx;
    word_t ny;
    word_t rho;
    word_t m1;
    word_t m2;
    word_t e;
    word_t u1;
    word_t u2;
    word_t u3;
    word_t c11;
    word_t c12;
    word_t c13;
    word_t c22;
    word_t c23;
    word_t a11;
    word_t a22;
    word_t w1;
    word_t w2;
    logic  bad;
    logic  clip;
  } mid_t;

  // {clip, value}
  function automatic logic [32:0] sat32(input logic signed [SAT_W-1:0] v);
    logic [32:0] r;
    if (v > WORD_MAX) begin
      r = {1'b1, 32'h7fff_ffff};
    end else if (v < WORD_MIN) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // round to nearest, ties up, dropping sh bits (sh is constant at each use)
  function automatic logic signed [SAT_W-1:0] rnd_shift(input logic signed [SAT_W-1:0] v,
                                                         input int unsigned sh);
    logic signed [SAT_W-1:0] half;
    half = SAT_W'(1) <<< (sh - 1);
    return (v + half) >>> sh;
  endfunction

endpackage

// File: hw/rtl/efn_div.sv
// pipelined restoring divider lane, one quotient bit per stage
// uses no package items
module efn_div #(
  parameter int NQ = 48
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NQ-1:0] num,
  input  logic [31:0]   den,
  output logic [NQ-1:0] quo
);

  logic [31:0]   rem  [1:NQ];
  logic [NQ-1:0] dq   [1:NQ];
  logic [31:0]   dens [1:NQ];

  for (genvar k = 0; k < NQ; k++) begin : g_step
    logic [31:0]   r_src;
    logic [NQ-1:0] d_src;
    logic [31:0]   n_src;
    logic [32:0]   t;
    logic          ge;
    if (k == 0) begin : g_first
      assign r_src = '0;
      assign d_src = num;
      assign n_src = den;
    end else begin : g_rest
      assign r_src = rem[k];
      assign d_src = dq[k];
      assign n_src = dens[k];
    end
    assign t  = {r_src, d_src[NQ-1]};
    assign ge = t >= {1'b0, n_src};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? 32'(t - {1'b0, n_src}) : t[31:0];
        dq[k+1]   <= {d_src[NQ-2:0], ge};
        dens[k+1] <= n_src;
      end
    end
  end

  assign quo = dq[NQ];

endmodule

// File: hw/rtl/euler_normal_flux_2d.sv
// euler normal flux: n_x*F_x + n_y*F_y of one cell state per item
// depends on efn_pkg, efn_div and euler_normal_flux_2d_macros.svh
//
// channels: s_* takes one cell item (normal, density, momenta, energy),
// m_* returns one flux item per input item, cfg_* writes gamma (always ready)
// throughput: one item per cycle while the output buffer has room, every stage
// registered, valid travels with data; path: an input capture stage, the three
// velocity dividers (Q16.16 at FRACTION_BITS = 16), one quotient bit per stage over
// FRACTION_BITS + 32 stages, then 13 multiply/round/saturate stages and
// the output buffer
// stall: a two-entry output buffer sits behind the pipe; the pipe and s_tready
// move only while that buffer has room, so nothing is lost or repeated and
// s_tready comes from registers only
// reset: rst (synchronous) empties pipe and buffer and loads gamma = 1.4
// density <= 0 gives zero fluxes with bad_density set and saturated clear
// gamma should only be written while no items are in flight
`include "euler_normal_flux_2d_macros.svh"
module euler_normal_flux_2d #(
  parameter int FRACTION_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  // config: heat_capacity_ratio
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [18:0]  cfg_data,
  // input item
  input  logic         s_tvalid,
  output logic         s_tready,
  // normal_x, normal_y, density, momentum_x, momentum_y, momentum_z, total_energy
  input  logic [223:0] s_tdata,
  // result item
  output logic         m_tvalid,
  input  logic         m_tready,
  // flux_mass, flux_momentum_x, flux_momentum_y, flux_momentum_z, flux_energy
  output logic [159:0] m_tdata,
  // bad_density, saturated
  output logic [1:0]   m_tuser
);
  import efn_pkg::*;

  localparam int F  = FRACTION_BITS;
  localparam int NQ = 32 + F;                       // quotient bits per divider
  localparam int GW = ((F + 1 > 19) ? F + 1 : 19) + 1; // gamma - 1 width
  localparam int NV = 1 + NQ + 13;                  // pipe stages
  localparam logic [GW-1:0] ONE_G = GW'(1) << F;

  // ------------------------------------------------------------------ config
  logic [18:0] gamma;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      gamma <= GAMMA_RESET;
    end else if (cfg_valid) begin
      gamma <= cfg_data;
    end
  end

  // ------------------------------------------------------- flow control
  logic [1:0]   cnt;
  logic         adv;
  logic [NV-1:0] vld;

  assign adv      = cnt != 2'd2;   // pipe moves while the buffer has room
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NV-2:0], s_tvalid};
    end
  end

  // ------------------------------------------------------- input capture
  item_t p0;
  always_ff @(posedge clk) begin
    if (adv) begin
      p0.nx  <= s_tdata[31:0];
      p0.ny  <= s_tdata[63:32];
      p0.rho <= s_tdata[95:64];
      p0.m1  <= s_tdata[127:96];
      p0.m2  <= s_tdata[159:128];
      p0.m3  <= s_tdata[191:160];
      p0.e   <= s_tdata[223:192];
      p0.bad <= $signed(s_tdata[95:64]) <= 32'sd0;
    end
  end

  // ------------------------------------------------------- velocity dividers
  logic [31:0]   abs1, abs2, abs3;
  logic [NQ-1:0] q1, q2, q3;
  item_t         pd [1:NQ];

  assign abs1 = p0.m1[31] ? 32'(-p0.m1) : p0.m1;
  assign abs2 = p0.m2[31] ? 32'(-p0.m2) : p0.m2;
  assign abs3 = p0.m3[31] ? 32'(-p0.m3) : p0.m3;

  efn_div #(.NQ(NQ)) u_div1 (.clk(clk), .en(adv), .num({abs1, {F{1'b0}}}),
                             .den(p0.rho), .quo(q1));
  efn_div #(.NQ(NQ)) u_div2 (.clk(clk), .en(adv), .num({abs2, {F{1'b0}}}),
                             .den(p0.rho), .quo(q2));
  efn_div #(.NQ(NQ)) u_div3 (.clk(clk), .en(adv), .num({abs3, {F{1'b0}}}),
                             .den(p0.rho), .quo(q3));

  // payload delay matching the divider depth
  always_ff @(posedge clk) begin
    if (adv) begin
      pd[1] <= p0;
      for (int k = 2; k <= NQ; k++) begin
        pd[k] <= pd[k-1];
      end
    end
  end

  // ------------------------------------------------------- stage a: signed velocities
  logic signed [NQ:0] uf1, uf2, uf3;
  logic [32:0]        su1, su2, su3;
  mid_t               ra, ra_next;

  assign uf1 = pd[NQ].m1[31] ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
  assign uf2 = pd[NQ].m2[31] ? -$signed({1'b0, q2}) : $signed({1'b0, q2});
  assign uf3 = pd[NQ].m3[31] ? -$signed({1'b0, q3}) : $signed({1'b0, q3});
  assign su1 = sat32(SAT_W'(uf1));
  assign su2 = sat32(SAT_W'(uf2));
  assign su3 = sat32(SAT_W'(uf3));

  always_comb begin
    ra_next      = '0;
    ra_next.nx   = pd[NQ].nx;
    ra_next.ny   = pd[NQ].ny;
    ra_next.rho  = pd[NQ].rho;
    ra_next.m1   = pd[NQ].m1;
    ra_next.m2   = pd[NQ].m2;
    ra_next.e    = pd[NQ].e;
    ra_next.bad  = pd[NQ].bad;
    ra_next.u1   = su1[31:0];
    ra_next.u2   = su2[31:0];
    ra_next.u3   = su3[31:0];
    ra_next.clip = su1[32] | su2[32] | su3[32];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ra <= ra_next;
    end
  end

  // ------------------------------------------------------- stage b: products of u
  mid_t               rb;
  logic signed [63:0] uu1, uu2, uu3, pc11, pc12, pc13, pc22, pc23;
  always_ff @(posedge clk) begin
    if (adv) begin
      rb   <= ra;
      uu1  <= ra.u1 * ra.u1;
      uu2  <= ra.u2 * ra.u2;
      uu3  <= ra.u3 * ra.u3;
      pc11 <= ra.m1 * ra.u1;
      pc12 <= ra.m1 * ra.u2;
      pc13 <= ra.m1 * ra.u3;
      pc22 <= ra.m2 * ra.u2;
      pc23 <= ra.m2 * ra.u3;
    end
  end

  // ------------------------------------------------------- stage c: |u|^2 and rho*u*u
  logic signed [SAT_W-1:0] qr;
  logic [32:0]             sc11, sc12, sc13, sc22, sc23;
  logic                    qclip;
  mid_t                    rc, rc_next;
  word_t                   q_c;

  assign qr    = rnd_shift(SAT_W'(uu1) + SAT_W'(uu2) + SAT_W'(uu3), F);
  assign qclip = qr > WORD_MAX;
  assign sc11  = sat32(rnd_shift(SAT_W'(pc11), F));
  assign sc12  = sat32(rnd_shift(SAT_W'(pc12), F));
  assign sc13  = sat32(rnd_shift(SAT_W'(pc13), F));
  assign sc22  = sat32(rnd_shift(SAT_W'(pc22), F));
  assign sc23  = sat32(rnd_shift(SAT_W'(pc23), F));

  always_comb begin
    rc_next      = rb;
    rc_next.c11  = sc11[31:0];
    rc_next.c12  = sc12[31:0];
    rc_next.c13  = sc13[31:0];
    rc_next.c22  = sc22[31:0];
    rc_next.c23  = sc23[31:0];
    rc_next.clip = rb.clip | qclip | sc11[32] | sc12[32] | sc13[32] | sc22[32] | sc23[32];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rc  <= rc_next;
      q_c <= qclip ? 32'sh7fff_ffff : word_t'(qr[31:0]);
    end
  end

  // ------------------------------------------------------- stage d: rho*q
  mid_t               rd;
  logic signed [63:0] prq;
  always_ff @(posedge clk) begin
    if (adv) begin
      rd  <= rc;
      prq <= rc.rho * q_c;
    end
  end

  // ------------------------------------------------------- stage e: kinetic energy
  mid_t        re, re_next;
  word_t       kin;
  logic [32:0] skin;
  assign skin = sat32(rnd_shift(SAT_W'(prq), F + 1));
  always_comb begin
    re_next      = rd;
    re_next.clip = rd.clip | skin[32];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      re  <= re_next;
      kin <= skin[31:0];
    end
  end

  // ------------------------------------------------------- stage f: E - kin, gamma - 1
  mid_t               rf;
  logic signed [32:0] diff;
  logic signed [GW-1:0] gm1;
  always_ff @(posedge clk) begin
    if (adv) begin
      rf   <= re;
      diff <= $signed({re.e[31], re.e}) - $signed({kin[31], kin});
      gm1  <= $signed({{(GW-19){1'b0}}, gamma}) - $signed(ONE_G);
    end
  end

  // ------------------------------------------------------- stage g: pressure product
  mid_t                    rg;
  logic signed [GW+32:0]   pp;
  always_ff @(posedge clk) begin
    if (adv) begin
      rg <= rf;
      pp <= gm1 * diff;
    end
  end

  // ------------------------------------------------------- stage h: pressure
  mid_t        rh, rh_next;
  word_t       p;
  logic [32:0] sp;
  assign sp = sat32(rnd_shift(SAT_W'(pp), F));
  always_comb begin
    rh_next      = rg;
    rh_next.clip = rg.clip | sp[32];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      rh <= rh_next;
      p  <= sp[31:0];
    end
  end

  // ------------------------------------------------------- stage i: enthalpy, diagonal terms
  mid_t        ri, ri_next;
  word_t       h;
  logic [32:0] sh, sa11, sa22;
  assign sh   = sat32(SAT_W'(rh.e) + SAT_W'(p));
  assign sa11 = sat32(SAT_W'(rh.c11) + SAT_W'(p));
  assign sa22 = sat32(SAT_W'(rh.c22) + SAT_W'(p));
  always_comb begin
    ri_next      = rh;
    ri_next.a11  = sa11[31:0];
    ri_next.a22  = sa22[31:0];
    ri_next.clip = rh.clip | sh[32] | sa11[32] | sa22[32];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      ri <= ri_next;
      h  <= sh[31:0];
    end
  end

  // ------------------------------------------------------- stage j: u*H products
  mid_t               rj;
  logic signed [63:0] pw1, pw2;
  always_ff @(posedge clk) begin
    if (adv) begin
      rj  <= ri;
      pw1 <= ri.u1 * h;
      pw2 <= ri.u2 * h;
    end
  end

  // ------------------------------------------------------- stage k: energy terms
  mid_t        rk, rk_next;
  logic [32:0] sw1, sw2;
  assign sw1 = sat32(rnd_shift(SAT_W'(pw1), F));
  assign sw2 = sat32(rnd_shift(SAT_W'(pw2), F));
  always_comb begin
    rk_next      = rj;
    rk_next.w1   = sw1[31:0];
    rk_next.w2   = sw2[31:0];
    rk_next.clip = rj.clip | sw1[32] | sw2[32];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      rk <= rk_next;
    end
  end

  // ------------------------------------------------------- stage l: normal projections
  logic signed [63:0] px [0:4];
  logic signed [63:0] py [0:4];
  logic               bad_l, clip_l;
  always_ff @(posedge clk) begin
    if (adv) begin
      px[0]  <= rk.nx * rk.m1;
      py[0]  <= rk.ny * rk.m2;
      px[1]  <= rk.nx * rk.a11;
      py[1]  <= rk.ny * rk.c12;
      px[2]  <= rk.nx * rk.c12;
      py[2]  <= rk.ny * rk.a22;
      px[3]  <= rk.nx * rk.c13;
      py[3]  <= rk.ny * rk.c23;
      px[4]  <= rk.nx * rk.w1;
      py[4]  <= rk.ny * rk.w2;
      bad_l  <= rk.bad;
      clip_l <= rk.clip;
    end
  end

  // ------------------------------------------------------- stage m: sums, bad density override
  logic [32:0] sf [0:4];
  logic [4:0]  fclip;
  logic [159:0] flux_m;
  logic         bad_m, sat_m;

  for (genvar i = 0; i < 5; i++) begin : g_dot
    assign sf[i]    = sat32(rnd_shift(SAT_W'(px[i]) + SAT_W'(py[i]), F));
    assign fclip[i] = sf[i][32];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bad_m <= bad_l;
      if (bad_l) begin
        flux_m <= '0;
        sat_m  <= 1'b0;
      end else begin
        flux_m <= {sf[4][31:0], sf[3][31:0], sf[2][31:0], sf[1][31:0], sf[0][31:0]};
        sat_m  <= clip_l | (|fclip);
      end
    end
  end

  // ------------------------------------------------------- output buffer
  logic [161:0] obuf [0:1];
  logic         wr_ptr, rd_ptr;
  logic         push, pop;

  assign push = adv && vld[NV-1];
  assign pop  = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (push) begin
      obuf[wr_ptr] <= {sat_m, bad_m, flux_m};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= 2'(cnt + {1'b0, push} - {1'b0, pop});
    end
  end

  assign m_tvalid = cnt != 2'd0;
  assign m_tdata  = obuf[rd_ptr][159:0];
  assign m_tuser  = obuf[rd_ptr][161:160];

  // ------------------------------------------------------- checks
  `EFN_ASSERT_NEVER(a_buf_count, clk, rst, cnt == 2'd3, "output buffer overflow")
  `EFN_ASSERT_IMPL(a_bad_zero, clk, rst, m_tvalid && m_tuser[0],
                   m_tdata == '0 && !m_tuser[1], "bad density item has nonzero flux")
  `EFN_ASSERT_NEXT(a_full_hold, clk, rst, cnt == 2'd2 && !m_tready,
                   cnt == 2'd2 && $stable(m_tdata), "full buffer changed while stalled")

endmodule
